[rtl/vrt_pkg.sv]
// Shared types and constants for the voxel ray traversal block.
package vrt_pkg;

   // Command codes on the request channel
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_ANSWER = 1'b1;

   // Result kinds on the response channel
   localparam logic [1:0] KIND_QUERY = 2'd0;
   localparam logic [1:0] KIND_HIT   = 2'd1;
   localparam logic [1:0] KIND_MISS  = 2'd2;

   // Axis numbers
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Fixed formats
   localparam int DIR_FRAC = 14;   // fraction bits of a direction component
   localparam int DIST_W   = 32;   // distance width
   localparam int MAG_W    = 16;   // magnitude of a direction component
   localparam int LIM_W    = 26;   // max_dist width
   localparam int OUT_W    = 16;   // voxel coordinate width on the response

   typedef struct packed {
      logic                    cmd;
      logic signed [31:0]      origin_x;
      logic signed [31:0]      origin_y;
      logic signed [31:0]      origin_z;
      logic signed [15:0]      dir_x;
      logic signed [15:0]      dir_y;
      logic signed [15:0]      dir_z;
      logic [LIM_W-1:0]        max_dist;
      logic                    voxel_solid;
   } req_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic signed [OUT_W-1:0] voxel_x;
      logic signed [OUT_W-1:0] voxel_y;
      logic signed [OUT_W-1:0] voxel_z;
      logic signed [OUT_W-1:0] prev_x;
      logic signed [OUT_W-1:0] prev_y;
      logic signed [OUT_W-1:0] prev_z;
      logic [2:0]              face;
   } rsp_type;

endpackage

[rtl/voxel_ray_traversal.sv]
// Voxel ray traversal: 3D DDA walk with a shared bit-serial divider for ray setup.
//
//   channel | direction | handshake               | payload
//   req_    | in        | req_valid / req_stall   | vrt_pkg::req_type (start or answer)
//   rsp_    | out       | rsp_valid / rsp_stall   | vrt_pkg::rsp_type (query, hit, miss)
//
// A start runs six divides on one restoring divider, one quotient bit a cycle,
// then picks the first axis. A zero direction component skips the two divides
// on its axis. A solid answer loads its result at the transfer; an air answer
// steps and, unless the step misses, then picks the next axis.
// Each result then sits in the output register until taken.
// Reset is synchronous and returns the block to idle with no ray in flight.
// req_stall stays high while a ray is being set up or stepped and while a
// result sits in the output register.
module voxel_ray_traversal #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vrt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vrt_pkg::rsp_type rsp_data
);

   localparam int NUM_W  = FRAC_BITS + vrt_pkg::DIR_FRAC + 1;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int QW     = (NUM_W > vrt_pkg::DIST_W) ? NUM_W : vrt_pkg::DIST_W + 1;
   localparam int LIM_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int LIM_DN = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
   localparam int DW     = vrt_pkg::DIST_W;
   localparam int MW     = vrt_pkg::MAG_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_ITER  = 3'd2;
   localparam logic [2:0] S_FIRST = 3'd3;
   localparam logic [2:0] S_PICK  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;
   localparam logic [2:0] S_WAIT  = 3'd6;
   localparam logic [2:0] S_STEP  = 3'd7;

   localparam logic [2:0] JOB_LAST = 3'd5;

   // Sequencer and divider
   logic [2:0]             state_ff, state_in;
   logic [2:0]             job_ff, job_in;
   logic [CNT_W-1:0]       iter_ff, iter_in;
   logic [MW-1:0]          rem_ff, rem_in;
   logic [NUM_W-1:0]       quo_ff, quo_in;

   // Ray state
   logic [FRAC_BITS-1:0]   frac_ff [3];
   logic [FRAC_BITS-1:0]   frac_in [3];
   logic [MW-1:0]          mag_ff [3];
   logic [MW-1:0]          mag_in [3];
   logic [2:0]             negd_ff, negd_in;
   logic [2:0]             sign_ff, sign_in;
   logic [COORD_BITS-1:0]  cur_ff [3];
   logic [COORD_BITS-1:0]  cur_in [3];
   logic [COORD_BITS-1:0]  prev_ff [3];
   logic [COORD_BITS-1:0]  prev_in [3];
   logic [DW-1:0]          bnd_ff [3];
   logic [DW-1:0]          bnd_in [3];
   logic [DW-1:0]          sdist_ff [3];
   logic [DW-1:0]          sdist_in [3];
   logic [DW-1:0]          limit_ff, limit_in;
   logic [1:0]             last_ff, last_in;
   logic [1:0]             pick_ff, pick_in;
   vrt_pkg::rsp_type       rsp_ff, rsp_in;

   // Combinational helpers
   logic                   req_xfer;
   logic [31:0]            org [3];
   logic [MW-1:0]          dir_u [3];
   logic [1:0]             job_axis;
   logic [MW-1:0]          job_mag;
   logic [FRAC_BITS:0]     f_val;
   logic [NUM_W-1:0]       num_bnd;
   logic [NUM_W-1:0]       num_step;
   logic [MW:0]            rem_sh;
   logic                   div_ge;
   logic [MW:0]            rem_nx;
   logic [NUM_W-1:0]       quo_nx;
   logic [QW-1:0]          q_wide;
   logic [DW-1:0]          q_sat;
   logic [1:0]             axis_sel;
   logic [DW-1:0]          old_bnd;
   logic [DW:0]            bnd_sum;
   logic                   miss;
   logic [57:0]            lim_wide;
   logic [DW-1:0]          lim_val;
   logic [2:0]             hit_face;

   assign req_stall = !(state_ff == S_IDLE || state_ff == S_WAIT);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   // Unpack the start fields per axis
   always_comb begin
      org[0]   = req_data.origin_x;
      org[1]   = req_data.origin_y;
      org[2]   = req_data.origin_z;
      dir_u[0] = req_data.dir_x;
      dir_u[1] = req_data.dir_y;
      dir_u[2] = req_data.dir_z;
   end

   // Convert the distance limit to FRAC_BITS fraction bits, saturating
   always_comb begin
      if (FRAC_BITS >= 16) begin
         lim_wide = {32'd0, req_data.max_dist} << LIM_UP;
      end else begin
         lim_wide = {32'd0, req_data.max_dist} >> LIM_DN;
      end
      lim_val = (|lim_wide[57:DW]) ? '1 : lim_wide[DW-1:0];
   end

   // Divider operands for the current job: even jobs step, odd jobs boundary
   assign job_axis = job_ff[2:1];
   assign job_mag  = mag_ff[job_axis];
   assign f_val    = negd_ff[job_axis] ? {1'b0, frac_ff[job_axis]}
                                       : {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_ff[job_axis]};
   assign num_bnd  = {f_val, {vrt_pkg::DIR_FRAC{1'b0}}};
   assign num_step = {1'b1, {(NUM_W-1){1'b0}}};

   // One restoring divide step
   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign div_ge = rem_sh >= {1'b0, job_mag};
   assign rem_nx = div_ge ? rem_sh - {1'b0, job_mag} : rem_sh;
   assign quo_nx = {quo_ff[NUM_W-2:0], div_ge};
   assign q_wide = QW'(quo_nx);
   assign q_sat  = (|q_wide[QW-1:DW]) ? '1 : q_wide[DW-1:0];

   // Axis with the nearest boundary; x wins only when strictly nearest
   always_comb begin
      if (bnd_ff[0] < bnd_ff[1] && bnd_ff[0] < bnd_ff[2]) begin
         axis_sel = vrt_pkg::AXIS_X;
      end else if (bnd_ff[1] < bnd_ff[2]) begin
         axis_sel = vrt_pkg::AXIS_Y;
      end else begin
         axis_sel = vrt_pkg::AXIS_Z;
      end
   end

   // Step arithmetic on the picked axis
   assign old_bnd  = bnd_ff[pick_ff];
   assign bnd_sum  = {1'b0, old_bnd} + {1'b0, sdist_ff[pick_ff]};
   assign miss     = (old_bnd == '1) || (old_bnd > limit_ff);
   assign hit_face = {last_ff, ~sign_ff[last_ff]};

   // Sequencer
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      iter_in  = iter_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      negd_in  = negd_ff;
      sign_in  = sign_ff;
      limit_in = limit_ff;
      last_in  = last_ff;
      pick_in  = pick_ff;
      rsp_in   = rsp_ff;
      for (int i = 0; i < 3; i++) begin
         frac_in[i]  = frac_ff[i];
         mag_in[i]   = mag_ff[i];
         cur_in[i]   = cur_ff[i];
         prev_in[i]  = prev_ff[i];
         bnd_in[i]   = bnd_ff[i];
         sdist_in[i] = sdist_ff[i];
      end

      case (state_ff)
         S_IDLE, S_WAIT: begin
            if (req_xfer && req_data.cmd == vrt_pkg::CMD_START) begin
               // latch a new ray; drop any ray in flight
               for (int i = 0; i < 3; i++) begin
                  frac_in[i] = org[i][FRAC_BITS-1:0];
                  mag_in[i]  = dir_u[i][MW-1] ? (~dir_u[i] + MW'(1)) : dir_u[i];
                  cur_in[i]  = COORD_BITS'($signed(org[i]) >>> FRAC_BITS);
                  prev_in[i] = COORD_BITS'($signed(org[i]) >>> FRAC_BITS);
                  negd_in[i] = dir_u[i][MW-1];
                  sign_in[i] = !dir_u[i][MW-1] && (dir_u[i] != '0);
               end
               limit_in = lim_val;
               job_in   = '0;
               state_in = S_LOAD;
            end else if (req_xfer && state_ff == S_WAIT) begin
               if (req_data.voxel_solid) begin
                  rsp_in.kind    = vrt_pkg::KIND_HIT;
                  rsp_in.voxel_x = vrt_pkg::OUT_W'({16'd0, cur_ff[0]});
                  rsp_in.voxel_y = vrt_pkg::OUT_W'({16'd0, cur_ff[1]});
                  rsp_in.voxel_z = vrt_pkg::OUT_W'({16'd0, cur_ff[2]});
                  rsp_in.prev_x  = vrt_pkg::OUT_W'({16'd0, prev_ff[0]});
                  rsp_in.prev_y  = vrt_pkg::OUT_W'({16'd0, prev_ff[1]});
                  rsp_in.prev_z  = vrt_pkg::OUT_W'({16'd0, prev_ff[2]});
                  rsp_in.face    = hit_face;
                  state_in       = S_RESP;
               end else begin
                  state_in = S_STEP;
               end
            end
         end

         S_LOAD: begin
            if (job_mag == '0) begin
               // zero direction: both distances infinite, skip the divide
               if (job_ff[0]) begin
                  bnd_in[job_axis] = '1;
               end else begin
                  sdist_in[job_axis] = '1;
               end
               job_in   = job_ff + 3'd1;
               state_in = (job_ff == JOB_LAST) ? S_FIRST : S_LOAD;
            end else begin
               rem_in   = '0;
               quo_in   = job_ff[0] ? num_bnd : num_step;
               iter_in  = '0;
               state_in = S_ITER;
            end
         end

         S_ITER: begin
            rem_in  = rem_nx[MW-1:0];
            quo_in  = quo_nx;
            iter_in = iter_ff + CNT_W'(1);
            if (iter_ff == CNT_W'(NUM_W - 1)) begin
               if (job_ff[0]) begin
                  bnd_in[job_axis] = q_sat;
               end else begin
                  sdist_in[job_axis] = q_sat;
               end
               job_in   = job_ff + 3'd1;
               state_in = (job_ff == JOB_LAST) ? S_FIRST : S_LOAD;
            end
         end

         S_FIRST, S_PICK: begin
            // pick the next axis and query the current voxel
            pick_in = axis_sel;
            if (state_ff == S_FIRST) begin
               last_in = axis_sel;
            end
            rsp_in         = '0;
            rsp_in.kind    = vrt_pkg::KIND_QUERY;
            rsp_in.voxel_x = vrt_pkg::OUT_W'({16'd0, cur_ff[0]});
            rsp_in.voxel_y = vrt_pkg::OUT_W'({16'd0, cur_ff[1]});
            rsp_in.voxel_z = vrt_pkg::OUT_W'({16'd0, cur_ff[2]});
            state_in       = S_RESP;
         end

         S_STEP: begin
            // advance one voxel along the picked axis
            for (int i = 0; i < 3; i++) begin
               prev_in[i] = cur_ff[i];
               if (pick_ff == 2'(i)) begin
                  cur_in[i] = sign_ff[i] ? cur_ff[i] + COORD_BITS'(1)
                                         : cur_ff[i] - COORD_BITS'(1);
                  bnd_in[i] = bnd_sum[DW] ? '1 : bnd_sum[DW-1:0];
               end
            end
            last_in = pick_ff;
            if (miss) begin
               rsp_in      = '0;
               rsp_in.kind = vrt_pkg::KIND_MISS;
               state_in    = S_RESP;
            end else begin
               state_in = S_PICK;
            end
         end

         S_RESP: begin
            // hold the result until transfer
            if (!rsp_stall) begin
               state_in = (rsp_ff.kind == vrt_pkg::KIND_QUERY) ? S_WAIT : S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      iter_ff  <= iter_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      negd_ff  <= negd_in;
      sign_ff  <= sign_in;
      limit_ff <= limit_in;
      last_ff  <= last_in;
      pick_ff  <= pick_in;
      rsp_ff   <= rsp_in;
      for (int i = 0; i < 3; i++) begin
         frac_ff[i]  <= frac_in[i];
         mag_ff[i]   <= mag_in[i];
         cur_ff[i]   <= cur_in[i];
         prev_ff[i]  <= prev_in[i];
         bnd_ff[i]   <= bnd_in[i];
         sdist_ff[i] <= sdist_in[i];
      end
   end

`ifndef SYNTHESIS
   // No request transfer while a result is pending
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   // A miss carries nothing but its kind
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == vrt_pkg::KIND_MISS) |->
      (rsp_data.voxel_x == '0 && rsp_data.voxel_y == '0 && rsp_data.voxel_z == '0 &&
       rsp_data.prev_x == '0 && rsp_data.prev_y == '0 && rsp_data.prev_z == '0 &&
       rsp_data.face == '0))
      else $error("miss result with nonzero fields");

   // A hit face names a real face
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == vrt_pkg::KIND_HIT) |-> (rsp_data.face <= 3'd5))
      else $error("hit face out of range");

   // A query transfer leaves the ray waiting for its answer
   a_query_waits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.kind == vrt_pkg::KIND_QUERY) |=>
      (state_ff == S_WAIT))
      else $error("query sent but not waiting for the answer");

   // A hit or miss transfer ends the ray
   a_end_idles: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.kind != vrt_pkg::KIND_QUERY) |=>
      (state_ff == S_IDLE))
      else $error("ray still active after a final result");
`endif

endmodule
